/* src/cache_tag_controller_two_modes_assert.svh */
// Assertion macros shared by the cache tag controller modules
`ifndef CACHE_TAG_CONTROLLER_TWO_MODES_ASSERT_SVH
`define CACHE_TAG_CONTROLLER_TWO_MODES_ASSERT_SVH

`ifndef ASSERT_OFF
`define CTC_ASSERT_IMPLY(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);
`define CTC_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTC_ASSERT_IMPLY(label, clock, resetn, ante, cons, msg)
`define CTC_ASSERT_NEXT(label, clock, resetn, ante, cons, msg)
`endif

`endif

/* src/ctc_pkg.sv */
// Types and constants of the cache tag controller
package ctc_pkg;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 18;
    localparam int IDX_W        = 10;
    localparam int CNT_W        = 32;
    localparam int WAYS         = 2;
    localparam int SETS_DEFAULT = 1024;
    localparam int CMDQ_DEPTH   = 2;

    localparam int DM_TAG_LSB   = 14;
    localparam int DM_IDX_LSB   = 4;
    localparam int SA_TAG_LSB   = 16;
    localparam int SA_TAG_W     = 16;
    localparam int SA_IDX_LSB   = 6;

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam logic [PADDR_W-3:0] REG_MODE = 1'b0;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_STORE = 1'b1
    } op_t;

    typedef enum logic {
        MODE_DIRECT  = 1'b0,
        MODE_TWO_WAY = 1'b1
    } mode_t;

    typedef struct packed {
        op_t               opcode;
        logic [ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic             hit;
        logic             memory_write;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] write_total;
    } result_t;

    typedef struct packed {
        op_t              op;
        mode_t            mode;
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] quot;
    } cmd_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } way_t;

    typedef struct packed {
        logic                 victim;
        way_t [WAYS-1:0]      ways;
    } row_t;

    localparam int ROW_BITS = $bits(row_t);

endpackage

/* src/cache_tag_controller_two_modes.sv */
// Top level of the two-mode cache tag controller
// A request passes the command queue, tag RAM read and result register
// to the result ports. The back end handles each request in two steps (tag
// RAM read, then write back), taking no new one before write back.
// After reset a clearing pass writes all SETS tag RAM rows, one per cycle;
// full stays high until the pass ends. Mode resets to direct-mapped.
module cache_tag_controller_two_modes #(
    parameter int SETS = ctc_pkg::SETS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  ctc_pkg::request_t             request,
    output logic                          empty,
    input  logic                          pop,
    output ctc_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctc_pkg::PADDR_W-1:0]   paddr,
    input  logic [ctc_pkg::PDATA_W-1:0]   pwdata,
    output logic [ctc_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import ctc_pkg::*;

    mode_t mode_reg;
    mode_t mode_next;
    logic  sel_mode;
    logic  clearing;
    logic  cmdq_full;
    logic  cmdq_push;
    logic  cmdq_valid;
    logic  cmdq_pop;
    cmd_t  cmd_in;
    cmd_t  cmd_out;

    assign pready   = 1'b1;
    assign sel_mode = (paddr[PADDR_W-1:2] == REG_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && sel_mode)
        begin
            mode_next = mode_t'(pwdata[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_DIRECT;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    assign prdata = sel_mode ? PDATA_W'(mode_reg) : '0;

    ctc_front #(
        .SETS (SETS)
    ) u_front (
        .push      (push),
        .request   (request),
        .full      (full),
        .mode      (mode_reg),
        .clearing  (clearing),
        .cmdq_full (cmdq_full),
        .cmdq_push (cmdq_push),
        .cmd       (cmd_in)
    );

    ctc_cmd_fifo #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmdq_push),
        .cmd_in  (cmd_in),
        .full    (cmdq_full),
        .valid   (cmdq_valid),
        .pop     (cmdq_pop),
        .cmd_out (cmd_out)
    );

    ctc_back #(
        .SETS (SETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmdq_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmdq_pop),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

/* src/ctc_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

/* src/ctc_front.sv */
// Front end: accept requests and split the address by mode
module ctc_front #(
    parameter int SETS = ctc_pkg::SETS_DEFAULT
) (
    input  logic              push,
    input  ctc_pkg::request_t request,
    output logic              full,
    input  ctc_pkg::mode_t    mode,
    input  logic              clearing,
    input  logic              cmdq_full,
    output logic              cmdq_push,
    output ctc_pkg::cmd_t     cmd
);

    import ctc_pkg::*;

    localparam int RECIP_SH = 2 * IDX_W;
    localparam int PROD_W   = RECIP_SH + IDX_W;
    localparam longint RECIP = (SETS >= (1 << IDX_W)) ? 0
                             : ((longint'(1) << RECIP_SH) + SETS - 1) / SETS;

    logic [IDX_W-1:0]  idx_raw;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        cmd.op   = request.opcode;
        cmd.mode = mode;
        unique case (mode)
            MODE_DIRECT:
            begin
                cmd.tag = request.address[DM_TAG_LSB +: TAG_W];
                idx_raw = request.address[DM_IDX_LSB +: IDX_W];
            end
            MODE_TWO_WAY:
            begin
                cmd.tag = TAG_W'(request.address[SA_TAG_LSB +: SA_TAG_W]);
                idx_raw = request.address[SA_IDX_LSB +: IDX_W];
            end
            default:
            begin
                cmd.tag = '0;
                idx_raw = '0;
            end
        endcase
        prod     = PROD_W'(idx_raw) * PROD_W'(RECIP);
        cmd.idx  = idx_raw;
        cmd.quot = prod[RECIP_SH +: IDX_W];
    end

    assign full      = cmdq_full || clearing;
    assign cmdq_push = push && !full;

endmodule

/* src/ctc_cmd_fifo.sv */
// Short command queue between front end and back end
`include "cache_tag_controller_two_modes_assert.svh"

module ctc_cmd_fifo #(
    parameter int DEPTH = ctc_pkg::CMDQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ctc_pkg::cmd_t cmd_in,
    output logic          full,
    output logic          valid,
    input  logic          pop,
    output ctc_pkg::cmd_t cmd_out
);

    import ctc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_Q = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t                entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W_Q-1:0]  count_reg;
    logic [CNT_W_Q-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign full    = (count_reg == CNT_W_Q'(DEPTH));
    assign valid   = (count_reg != '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    `CTC_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, count_reg != CNT_W_Q'(DEPTH), "push into full command queue")
    `CTC_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, count_reg != '0, "pop from empty command queue")

endmodule

/* src/ctc_back.sv */
// Back end: clearing pass, tag lookup, tag store update, totals and result register
`include "cache_tag_controller_two_modes_assert.svh"

module ctc_back #(
    parameter int SETS = ctc_pkg::SETS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  ctc_pkg::cmd_t    cmd,
    output logic             cmd_pop,
    output logic             clearing,
    output logic             empty,
    input  logic             pop,
    output ctc_pkg::result_t result
);

    import ctc_pkg::*;

    localparam int ROW_W = $clog2(SETS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SETS - 1);
    localparam logic [IDX_W-1:0] SETS_LO  = IDX_W'(SETS);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [ROW_W-1:0] clr_reg;
    logic [ROW_W-1:0] clr_next;
    cmd_t             cur_reg;
    cmd_t             cur_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             way_reg;
    logic             way_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          out_next;
    logic [CNT_W-1:0] miss_reg;
    logic [CNT_W-1:0] miss_next;
    logic [CNT_W-1:0] write_reg;
    logic [CNT_W-1:0] write_next;

    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [ROW_W-1:0]    ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;

    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] idx_red;
    logic [ROW_W-1:0] row_calc;
    logic             way_calc;
    row_t             rd;
    row_t             upd;
    logic             hit;
    logic             mw;
    logic             vic;

    ctc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        base    = cmd.quot * SETS_LO;
        idx_red = cmd.idx - base;
        unique case (cmd.mode)
            MODE_DIRECT:
            begin
                row_calc = ROW_W'(idx_red >> 1);
                way_calc = idx_red[0];
            end
            MODE_TWO_WAY:
            begin
                row_calc = ROW_W'(idx_red);
                way_calc = 1'b0;
            end
            default:
            begin
                row_calc = '0;
                way_calc = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd  = row_t'(ram_rdata);
        upd = rd;
        hit = 1'b0;
        mw  = 1'b0;
        vic = rd.victim;
        unique case (cur_reg.mode)
            MODE_DIRECT:
            begin
                hit = rd.ways[way_reg].valid && (rd.ways[way_reg].tag == cur_reg.tag);
                if (cur_reg.op == OP_LOAD)
                begin
                    upd.ways[way_reg].tag   = cur_reg.tag;
                    upd.ways[way_reg].valid = 1'b1;
                end
                mw = (cur_reg.op == OP_STORE);
            end
            MODE_TWO_WAY:
            begin
                priority if (rd.ways[0].valid && (rd.ways[0].tag == cur_reg.tag))
                begin
                    hit = 1'b1;
                    if (cur_reg.op == OP_STORE)
                    begin
                        upd.ways[0].dirty = 1'b1;
                    end
                    upd.victim = 1'b1;
                end
                else if (rd.ways[1].valid && (rd.ways[1].tag == cur_reg.tag))
                begin
                    hit = 1'b1;
                    if (cur_reg.op == OP_STORE)
                    begin
                        upd.ways[1].dirty = 1'b1;
                    end
                    upd.victim = 1'b0;
                end
                else
                begin
                    mw              = rd.ways[vic].valid && rd.ways[vic].dirty;
                    upd.ways[vic]   = '{valid: 1'b1, dirty: (cur_reg.op == OP_STORE),
                                        tag: cur_reg.tag};
                    upd.victim      = ~vic;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        row_next       = row_reg;
        way_next       = way_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        miss_next      = miss_reg;
        write_next     = write_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = row_calc;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ROW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    ram_re     = 1'b1;
                    cur_next   = cmd;
                    row_next   = row_calc;
                    way_next   = way_calc;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || pop)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_reg;
                    ram_wdata = upd;
                    if (!hit && (miss_reg != CNT_MAX))
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                    if (mw && (write_reg != CNT_MAX))
                    begin
                        write_next = write_reg + 1'b1;
                    end
                    out_next.hit          = hit;
                    out_next.memory_write = mw;
                    out_next.miss_total   = miss_next;
                    out_next.write_total  = write_next;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cur_reg       <= '0;
            row_reg       <= '0;
            way_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            miss_reg      <= '0;
            write_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cur_reg       <= cur_next;
            row_reg       <= row_next;
            way_reg       <= way_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            miss_reg      <= miss_next;
            write_reg     <= write_next;
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    `CTC_ASSERT_IMPLY(a_no_pop_in_clear, clk, rst_n, state_reg == ST_CLEAR, !cmd_pop, "command taken during clearing pass")
    `CTC_ASSERT_IMPLY(a_result_from_update, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_UPDATE), "result without update")
    `CTC_ASSERT_NEXT(a_miss_monotonic, clk, rst_n, 1'b1, miss_reg >= $past(miss_reg), "miss total decreased")

endmodule
